/* rtl/indexed_insert_delete_list_assert.svh */
// Assertion macros for the indexed insert/delete list.
// Included by the top level; no other dependencies.
`ifndef INDEXED_INSERT_DELETE_LIST_ASSERT_SVH
`define INDEXED_INSERT_DELETE_LIST_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define IIDL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high.
`define IIDL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/iidl_pkg.sv */
// Shared types and codes for the indexed insert/delete list.
// No dependencies.
package iidl_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int GRP_SIZE     = 8;   // cells per first-level read group

   localparam logic [2:0] ACT_GET  = 3'd0;
   localparam logic [2:0] ACT_HEAD = 3'd1;
   localparam logic [2:0] ACT_TAIL = 3'd2;
   localparam logic [2:0] ACT_AT   = 3'd3;
   localparam logic [2:0] ACT_DEL  = 3'd4;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef enum logic {
      FSM_IDLE,
      FSM_REDUCE
   } fsm_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INS,
      CELL_DEL
   } cell_op_type;

   typedef enum logic [1:0] {
      RD_ZERO,
      RD_ELEM,
      RD_ERR
   } rd_kind_type;

   typedef struct packed {
      cell_op_type        op;
      logic signed [31:0] value;
   } cell_ctl_type;

   typedef struct packed {
      logic [2:0]         action;
      logic [6:0]         position;
      logic signed [31:0] new_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic [1:0]         status;
      logic [6:0]         length;
   } rsp_type;

endpackage

/* rtl/iidl_cell.sv */
// One element slot of the list chain: shifts with its neighbors on insert/delete.
// Depends on iidl_pkg.
module iidl_cell
   import iidl_pkg::*;
#(
   parameter int CNT_W = 7,
   parameter int IDX   = 0
) (
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic [CNT_W-1:0]   pos,
   input  logic signed [31:0] left_data,
   input  logic signed [31:0] right_data,
   output logic signed [31:0] data,
   output logic signed [31:0] sel_data
);

   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

   logic signed [31:0] data_ff;
   logic signed [31:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         CELL_INS: begin
            if (MY_IDX > pos) begin
               data_in = left_data;
            end else if (MY_IDX == pos) begin
               data_in = ctl.value;
            end
         end
         CELL_DEL: begin
            if (MY_IDX >= pos) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   assign sel_data = (MY_IDX == pos) ? data_ff : 32'sd0;

endmodule

/* rtl/indexed_insert_delete_list.sv */
// Top level of the indexed insert/delete list: control, cell chain, read reduction.
// Depends on iidl_pkg, iidl_cell and indexed_insert_delete_list_assert.svh.
//
// Usage:
//   req channel (req_valid/req_ready/req_payload) takes one request item:
//   get, insert at head, insert at tail, insert at index, or delete at index.
//   rsp channel (rsp_valid/rsp_ready/rsp_payload) returns exactly one item
//   per request: read value, status and the element count afterwards.
// Timing:
//   An item is accepted in the idle state; the cell chain shifts at that
//   edge. The next cycle finishes the registered OR tree that selects the
//   read element and loads the result into the output register. A new
//   item is accepted only in the idle state, not while the last one is in
//   the reduce state. The next item is accepted only when the output
//   register is empty or its result leaves at that same edge.
// Reset: synchronous, active high; the count goes to zero and no result is
//   pending. Element contents are not cleared; only slots below the count
//   are ever read.
// Stall: while rsp_ready is low a waiting result holds and req_ready stays
//   low, so no further item enters until that result is taken.
module indexed_insert_delete_list
   import iidl_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int CMP_W   = (CNT_W > 7) ? CNT_W : 7;
   localparam int NUM_GRP = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

   fsm_type          state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic [1:0]       status_ff, status_in;
   rd_kind_type      rd_kind_ff, rd_kind_in;
   logic signed [31:0] grp_ff [NUM_GRP];
   logic signed [31:0] grp_in [NUM_GRP];
   logic signed [31:0] tree_or;

   cell_ctl_type       ctl;
   logic [CNT_W-1:0]   cell_pos;
   logic signed [31:0] cell_data [CAPACITY];
   logic signed [31:0] cell_sel  [CAPACITY];

   logic             accept;
   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic             full;

   assign accept  = req_valid && req_ready;
   assign pos_ext = CMP_W'(req_payload.position);
   assign cnt_ext = CMP_W'(count_ff);
   assign full    = (count_ff == CNT_W'(CAPACITY));

   // Request decode and control state
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      rd_kind_in   = rd_kind_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      ctl.op       = CELL_HOLD;
      ctl.value    = req_payload.new_value;
      cell_pos     = pos_ext[CNT_W-1:0];
      case (state_ff)
         FSM_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (accept) begin
               state_in   = FSM_REDUCE;
               status_in  = ST_DONE;
               rd_kind_in = RD_ZERO;
               case (req_payload.action)
                  ACT_GET: begin
                     if (pos_ext < cnt_ext) begin
                        rd_kind_in = RD_ELEM;
                     end else begin
                        rd_kind_in = RD_ERR;
                        status_in  = ST_RANGE;
                     end
                  end
                  ACT_HEAD: begin
                     cell_pos = '0;
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        ctl.op   = CELL_INS;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_TAIL: begin
                     cell_pos = count_ff;
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        ctl.op   = CELL_INS;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_AT: begin
                     if (pos_ext > cnt_ext) begin
                        status_in = ST_RANGE;
                     end else if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        ctl.op   = CELL_INS;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  ACT_DEL: begin
                     if (pos_ext >= cnt_ext) begin
                        status_in = ST_RANGE;
                     end else begin
                        ctl.op   = CELL_DEL;
                        count_in = count_ff - CNT_W'(1);
                     end
                  end
                  default: begin
                     status_in = ST_DONE;
                  end
               endcase
            end
         end
         FSM_REDUCE: begin
            state_in       = FSM_IDLE;
            rsp_valid_in   = 1'b1;
            rsp_in.status  = status_ff;
            rsp_in.length  = cnt_ext[6:0];
            case (rd_kind_ff)
               RD_ELEM: rsp_in.read_value = tree_or;
               RD_ERR:  rsp_in.read_value = -32'sd1;
               default: rsp_in.read_value = 32'sd0;
            endcase
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      rd_kind_ff <= rd_kind_in;
      rsp_ff     <= rsp_in;
      grp_ff     <= grp_in;
   end

   // Cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [31:0] left_d, right_d;
      if (i == 0) begin : g_first
         assign left_d = 32'sd0;
      end else begin : g_mid_l
         assign left_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_d = cell_data[i];
      end else begin : g_mid_r
         assign right_d = cell_data[i+1];
      end
      iidl_cell #(
         .CNT_W (CNT_W),
         .IDX   (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .pos        (cell_pos),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[i]),
         .sel_data   (cell_sel[i])
      );
   end

   // Read tree: group ORs registered at accept, final OR in the next cycle
   always_comb begin
      for (int g = 0; g < NUM_GRP; g++) begin
         grp_in[g] = 32'sd0;
         for (int k = 0; k < GRP_SIZE; k++) begin
            if (g * GRP_SIZE + k < CAPACITY) begin
               grp_in[g] = grp_in[g] | cell_sel[g * GRP_SIZE + k];
            end
         end
      end
   end

   always_comb begin
      tree_or = 32'sd0;
      for (int g = 0; g < NUM_GRP; g++) begin
         tree_or = tree_or | grp_ff[g];
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`include "indexed_insert_delete_list_assert.svh"

   `IIDL_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `IIDL_ASSERT_NEXT(a_accept_reduce, clock, reset, accept, state_ff == FSM_REDUCE, "accepted item not in reduce")
   `IIDL_ASSERT_NEXT(a_reduce_rsp, clock, reset, state_ff == FSM_REDUCE, rsp_valid_ff, "no result after reduce")
   `IIDL_ASSERT_NEXT(a_ins_count, clock, reset, accept && ctl.op == CELL_INS, count_ff == $past(count_ff) + CNT_W'(1), "insert did not grow count")

endmodule

/* verif/tb.sv */
// Testbench for indexed_insert_delete_list: request/result streams with random gaps and stalls.
// Keeps its own copy of the list to predict every result; depends on iidl_pkg and the RTL top.
module tb;
   import iidl_pkg::*;

   localparam int LIST_CAP    = CAPACITY_DEF;
   localparam int POS_MAX     = 127;
   localparam int RAND_ITEMS  = 500;
   localparam int STUCK_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 16;

   // codes the block must treat as no-ops
   localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

   typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_type;
   typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_type;

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   indexed_insert_delete_list #(.CAPACITY(LIST_CAP)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- list copy
   logic signed [31:0] list_vals [LIST_CAP];
   int list_len = 0;
   int n_get = 0, n_ins = 0, n_del = 0, n_range = 0, n_full = 0, peak_len = 0;

   function automatic logic [1:0] insert_elem(int at, logic signed [31:0] v);
      if (list_len >= LIST_CAP) return ST_FULL;
      for (int i = list_len; i > at; i--) list_vals[i] = list_vals[i - 1];
      list_vals[at] = v;
      list_len++;
      return ST_DONE;
   endfunction

   // Applies one request to the list copy and returns the result it must produce.
   function automatic rsp_type list_update(req_type rq);
      rsp_type rs;
      int      pos;
      rs = '0;
      rs.status = ST_DONE;
      pos = int'(rq.position);
      case (rq.action)
         ACT_GET: begin
            n_get++;
            if (pos < list_len) begin
               rs.read_value = list_vals[pos];
            end else begin
               rs.read_value = -1;
               rs.status = ST_RANGE;
            end
         end
         ACT_HEAD: begin
            n_ins++;
            rs.status = insert_elem(0, rq.new_value);
         end
         ACT_TAIL: begin
            n_ins++;
            rs.status = insert_elem(list_len, rq.new_value);
         end
         ACT_AT: begin
            n_ins++;
            // range check wins over the full check
            if (pos > list_len) rs.status = ST_RANGE;
            else rs.status = insert_elem(pos, rq.new_value);
         end
         ACT_DEL: begin
            n_del++;
            if (pos >= list_len) begin
               rs.status = ST_RANGE;
            end else begin
               for (int i = pos; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
               list_len--;
            end
         end
         default: ;
      endcase
      if (rs.status == ST_RANGE) n_range++;
      if (rs.status == ST_FULL) n_full++;
      if (list_len > peak_len) peak_len = list_len;
      rs.length = 7'(list_len);
      return rs;
   endfunction

   // ---------------------------------------------------------------- stimulus
   req_type req_backlog [$];
   rsp_type due_results [$];
   int gen_len    = 0;   // length the list will have once the backlog so far is applied
   int rand_items = 0;

   task automatic queue_req(logic [2:0] a, logic [6:0] p, logic [31:0] v);
      req_type rq;
      rq.action    = a;
      rq.position  = p;
      rq.new_value = v;
      req_backlog.push_back(rq);
      case (a)
         ACT_HEAD, ACT_TAIL: if (gen_len < LIST_CAP) gen_len++;
         ACT_AT: if (int'(p) <= gen_len && gen_len < LIST_CAP) gen_len++;
         ACT_DEL: if (int'(p) < gen_len) gen_len--;
         default: ;
      endcase
   endtask

   task automatic queue_random(int ins_pct, int del_pct);
      int          roll;
      logic [2:0]  a;
      logic [6:0]  p;
      logic [31:0] v;
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
         a = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
      end else if (roll < 2 + ins_pct) begin
         case ($urandom_range(0, 2))
            0: a = ACT_HEAD;
            1: a = ACT_TAIL;
            default: a = ACT_AT;
         endcase
      end else if (roll < 2 + ins_pct + del_pct) begin
         a = ACT_DEL;
      end else begin
         a = ACT_GET;
      end
      if (gen_len == 0 || $urandom_range(0, 9) == 0) begin
         // off-by-one boundary or anywhere in the field
         p = ($urandom_range(0, 1) == 0) ? 7'(gen_len) : 7'($urandom_range(0, POS_MAX));
      end else begin
         case (a)
            ACT_GET, ACT_DEL: p = 7'($urandom_range(0, gen_len - 1));
            ACT_AT: p = 7'($urandom_range(0, gen_len));
            default: p = 7'($urandom_range(0, POS_MAX));
         endcase
      end
      case ($urandom_range(0, 15))
         0: v = 32'h8000_0000;
         1: v = 32'h7FFF_FFFF;
         2: v = 32'hFFFF_FFFF;
         3: v = 32'h0000_0000;
         default: v = $urandom;
      endcase
      queue_req(a, p, v);
      if (a < ACT_UNUSED_FIRST) rand_items++;
   endtask

   // ---------------------------------------------------------------- driver
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) due_results.push_back(list_update(req_payload));
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               req_payload <= req_backlog.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver stalls
   rx_mode_type rx_mode   = RX_FREE;
   int          mode_left = 0;
   logic [15:0] stall_pat = 16'b1110_0110_1000_1111;

   always @(posedge clock) begin
      if (mode_left == 0) begin
         rx_mode <= rx_mode_type'($urandom_range(0, 2));
         mode_left <= $urandom_range(16, 128);
      end else begin
         mode_left <= mode_left - 1;
      end
      stall_pat <= {stall_pat[14:0], stall_pat[15]};
      case (rx_mode)
         RX_FREE: rsp_ready <= 1'b1;
         RX_RANDOM: rsp_ready <= ($urandom_range(0, 99) >= 40);
         default: rsp_ready <= stall_pat[0];
      endcase
   end

   // ---------------------------------------------------------------- monitor
   int mismatch_count = 0;
   int results_seen   = 0;

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (due_results.size() == 0) begin
            $display("%0t: result with no request outstanding: value %0d status %0d length %0d",
                     $time, rsp_payload.read_value, rsp_payload.status, rsp_payload.length);
            mismatch_count++;
         end else begin
            want = due_results.pop_front();
            if (rsp_payload.read_value !== want.read_value) begin
               $display("%0t: read_value expected %0d got %0d", $time,
                        want.read_value, rsp_payload.read_value);
               mismatch_count++;
            end
            if (rsp_payload.status !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time,
                        want.status, rsp_payload.status);
               mismatch_count++;
            end
            if (rsp_payload.length !== want.length) begin
               $display("%0t: length expected %0d got %0d", $time,
                        want.length, rsp_payload.length);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   int stuck_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
   end

   initial begin
      while (stuck_cycles < STUCK_LIMIT) @(posedge clock);
      $display("%0t: no item moved for %0d cycles", $time, STUCK_LIMIT);
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------- main sequence
   initial begin : main_seq
      phase_type phase;

      // empty list: every indexed access is out of range
      queue_req(ACT_GET, 7'd0, 32'h1234_5678);
      queue_req(ACT_DEL, 7'd0, 32'h0);
      queue_req(ACT_AT, 7'd1, 32'h1);
      queue_req(ACT_AT, 7'd127, 32'hFFFF_FFFF);
      // build a short list from all insert flavors
      queue_req(ACT_AT, 7'd0, 32'h7FFF_FFFF);
      queue_req(ACT_HEAD, 7'd127, 32'h8000_0000);
      queue_req(ACT_TAIL, 7'd0, 32'hFFFF_FFFF);
      queue_req(ACT_TAIL, 7'd127, 32'h0);
      queue_req(ACT_AT, 7'd4, 32'h5555_5555);
      queue_req(ACT_AT, 7'd2, 32'hAAAA_AAAA);
      queue_req(ACT_AT, 7'd7, 32'h1);
      // reads at both ends and past the end
      queue_req(ACT_GET, 7'd0, 32'h0);
      queue_req(ACT_GET, 7'd5, 32'hFFFF_FFFF);
      queue_req(ACT_GET, 7'd6, 32'h0);
      queue_req(ACT_GET, 7'd127, 32'h0);
      // deletes: past the end, last, first, middle
      queue_req(ACT_DEL, 7'd6, 32'h0);
      queue_req(ACT_DEL, 7'd127, 32'h0);
      queue_req(ACT_DEL, 7'd5, 32'h0);
      queue_req(ACT_DEL, 7'd0, 32'h0);
      queue_req(ACT_DEL, 7'd1, 32'h0);
      for (int c = ACT_UNUSED_FIRST; c <= ACT_UNUSED_LAST; c++)
         queue_req(3'(c), 7'($urandom_range(0, POS_MAX)), $urandom);
      queue_req(ACT_GET, 7'd2, 32'h0);

      // fill to capacity first, empty it, then random phases
      phase = PH_FILL;
      while (rand_items < RAND_ITEMS) begin
         case (phase)
            PH_FILL: begin
               while (gen_len < LIST_CAP) queue_random(85, 5);
               repeat (8) queue_random(70, 0);
            end
            PH_DRAIN: begin
               while (gen_len > 0) queue_random(10, 75);
               repeat (4) queue_random(30, 40);
            end
            default: repeat ($urandom_range(20, 60)) queue_random(40, 35);
         endcase
         phase = (phase == PH_FILL) ? PH_DRAIN : phase_type'($urandom_range(0, 2));
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_valid || due_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (due_results.size() != 0)
         $display("%0t: %0d results never arrived", $time, due_results.size());
      $display("Covered %0d results: %0d gets, %0d inserts, %0d deletes, peak length %0d.",
               results_seen, n_get, n_ins, n_del, peak_len);
      $display("Out-of-range requests: %0d, inserts dropped on a full list: %0d.",
               n_range, n_full);
      if (mismatch_count == 0 && due_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/iidl_pkg.sv
rtl/iidl_cell.sv
rtl/indexed_insert_delete_list.sv
verif/tb.sv
